// ----- design/bbr_pkg.sv -----
// ---------------------------------------------------------------------------
// bbr_pkg: shared types for the base64url bit reader
// Word formats, opcodes, sequencer states and the alphabet decoder.
// ---------------------------------------------------------------------------
package bbr_pkg;

	typedef enum logic [1:0] {
		OP_RESTART    = 2'd0,
		OP_PUSH       = 2'd1,
		OP_READ_BITS  = 2'd2,
		OP_READ_UNARY = 2'd3
	} op_t;

	typedef struct packed {
		op_t        opcode;
		logic [7:0] character;
		logic [5:0] bit_count;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        failed;
		logic [8:0]  bits_left;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FETCH,
		ST_DONE
	} state_t;

	// Stored code: alphabet index in the low six bits, top bit marks a bad character.
	localparam int CODE_W  = 7;
	localparam int CHAR_BITS = 6;

	typedef struct packed {
		logic unary;
		logic single;
	} unit_ctl_t;

	typedef struct packed {
		logic [2:0] k;
		logic [5:0] chunk;
		logic [5:0] buf_next;
		logic       found;
		logic [2:0] tz;
	} unit_res_t;

	function automatic logic [CODE_W-1:0] alpha_index(input logic [7:0] c);
		logic [CODE_W-1:0] code;
		code = 7'd64;
		if (c >= 8'h41 && c <= 8'h5A) begin
			code = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			code = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			code = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2D) begin
			code = 7'd62;
		end else if (c == 8'h5F) begin
			code = 7'd63;
		end
		return code;
	endfunction

endpackage

// ----- design/base64url_bit_reader_unit.sv -----
// ---------------------------------------------------------------------------
// base64url_bit_reader_unit: LSB-first bit reader over a base64url string
// Stores pushed characters and serves bit reads and unary reads from them.
// ---------------------------------------------------------------------------
// A restart or push word shows its result in the cycle after accept.
// A read takes each group of buffered bits in its own step, and a character
// refill is a memory read, then a buffer load; a bit read adds a closing step.
// One word is in flight at a time; the next is taken in the cycle after the
// response handshake. Reset clears the string, buffer and flag.
// ---------------------------------------------------------------------------
module base64url_bit_reader_unit #(
	parameter int MAX_CHARS     = 64,
	parameter int MAX_READ_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bbr_pkg::req_t req_word,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bbr_pkg::rsp_t rsp_word
);

	// Count width must hold MAX_CHARS itself; the address only indexes entries.
	localparam int CW = $clog2(MAX_CHARS + 1);
	localparam int AW = $clog2(MAX_CHARS);
	// Read bit index and remaining count, each able to hold MAX_READ_BITS.
	localparam int IW = $clog2(MAX_READ_BITS + 1);
	// Unary zero counter covers every bit the store can hold.
	localparam int ZW = $clog2(bbr_pkg::CHAR_BITS * MAX_CHARS + 1);
	localparam int BW = CW + 3;

	bbr_pkg::state_t state_q, state_d;
	bbr_pkg::op_t    op_q, op_d;

	// Architectural reader state.
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [5:0]    buf_q, buf_d;
	logic [2:0]    held_q, held_d;
	logic          fail_q, fail_d;

	// Per-word working registers.
	logic [MAX_READ_BITS-1:0] acc_q, acc_d;
	logic [IW-1:0]            idx_q, idx_d;
	logic [IW-1:0]            rem_q, rem_d;
	logic [ZW-1:0]            zeros_q, zeros_d;
	logic [31:0]              value_q, value_d;

	logic                       wr_en;
	logic                       rd_en;
	logic [bbr_pkg::CODE_W-1:0] rd_code;
	bbr_pkg::unit_ctl_t         unit_ctl;
	bbr_pkg::unit_res_t         unit_res;
	logic [2:0]                 limit;
	logic [IW-1:0]              sat_count;
	logic [63:0]                acc_ext;
	logic [CW-1:0]              unread;
	logic [BW-1:0]              bits_left_w;

	bbr_char_store #(
		.DEPTH(MAX_CHARS),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(bbr_pkg::alpha_index(req_word.character)),
		.rd_en  (rd_en),
		.rd_addr(pos_q[AW-1:0]),
		.rd_data(rd_code)
	);

	// The buffer only ever holds zeros above its held bits, so the unit can
	// work on it directly. A read that already failed takes a single bit.
	assign unit_ctl.unary  = (op_q == bbr_pkg::OP_READ_UNARY);
	assign unit_ctl.single = fail_q;
	assign limit           = (rem_q >= IW'(6)) ? 3'd6 : rem_q[2:0];

	bbr_bit_unit u_unit (
		.ctl  (unit_ctl),
		.bits (buf_q),
		.held (held_q),
		.limit(limit),
		.res  (unit_res)
	);

	assign sat_count = (int'(req_word.bit_count) > MAX_READ_BITS) ?
		IW'(MAX_READ_BITS) : IW'(req_word.bit_count);
	assign acc_ext = 64'(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbr_pkg::ST_IDLE;
			op_q    <= bbr_pkg::OP_RESTART;
			count_q <= '0;
			pos_q   <= '0;
			buf_q   <= '0;
			held_q  <= '0;
			fail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			buf_q   <= buf_d;
			held_q  <= held_d;
			fail_q  <= fail_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q   <= acc_d;
		idx_q   <= idx_d;
		rem_q   <= rem_d;
		zeros_q <= zeros_d;
		value_q <= value_d;
	end

	// Sequencer: IDLE takes a word, RUN drains the buffer through the shared
	// unit, asks for a refill or ends the read, FETCH loads the character read
	// from memory or fails on a bad one, DONE holds the result until it is taken.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		count_d = count_q;
		pos_d   = pos_q;
		buf_d   = buf_q;
		held_d  = held_q;
		fail_d  = fail_q;
		acc_d   = acc_q;
		idx_d   = idx_q;
		rem_d   = rem_q;
		zeros_d = zeros_q;
		value_d = value_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;

		unique case (state_q)
			bbr_pkg::ST_IDLE: begin
				if (req_valid) begin
					op_d    = req_word.opcode;
					value_d = '0;
					acc_d   = '0;
					idx_d   = '0;
					rem_d   = sat_count;
					zeros_d = '0;
					unique case (req_word.opcode)
						bbr_pkg::OP_RESTART: begin
							count_d = '0;
							pos_d   = '0;
							buf_d   = '0;
							held_d  = '0;
							fail_d  = 1'b0;
							state_d = bbr_pkg::ST_DONE;
						end
						bbr_pkg::OP_PUSH: begin
							if (count_q >= CW'(MAX_CHARS)) begin
								fail_d = 1'b1;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CW'(1);
							end
							state_d = bbr_pkg::ST_DONE;
						end
						bbr_pkg::OP_READ_BITS,
						bbr_pkg::OP_READ_UNARY: begin
							state_d = bbr_pkg::ST_RUN;
						end
						default: begin
							state_d = bbr_pkg::ST_DONE;
						end
					endcase
				end
			end

			bbr_pkg::ST_RUN: begin
				if (op_q == bbr_pkg::OP_READ_BITS) begin
					if (rem_q == '0) begin
						value_d = acc_ext[31:0];
						state_d = bbr_pkg::ST_DONE;
					end else if (held_q != 3'd0) begin
						// Bits already buffered are taken even after a failure.
						acc_d  = acc_q | (MAX_READ_BITS'(unit_res.chunk) << idx_q);
						buf_d  = unit_res.buf_next;
						held_d = held_q - unit_res.k;
						idx_d  = idx_q + IW'(unit_res.k);
						rem_d  = rem_q - IW'(unit_res.k);
					end else if (fail_q) begin
						value_d = acc_ext[31:0];
						state_d = bbr_pkg::ST_DONE;
					end else if (pos_q >= count_q) begin
						// Past the end: the missing bits stay zero.
						fail_d  = 1'b1;
						value_d = acc_ext[31:0];
						state_d = bbr_pkg::ST_DONE;
					end else begin
						rd_en   = 1'b1;
						state_d = bbr_pkg::ST_FETCH;
					end
				end else begin
					if (held_q != 3'd0) begin
						buf_d  = unit_res.buf_next;
						held_d = held_q - unit_res.k;
						if (fail_q) begin
							// With the flag up, a zero bit ends the read as a failure.
							value_d = buf_q[0] ? 32'(zeros_q) : '1;
							state_d = bbr_pkg::ST_DONE;
						end else if (unit_res.found) begin
							value_d = 32'(zeros_q + ZW'(unit_res.tz));
							state_d = bbr_pkg::ST_DONE;
						end else begin
							zeros_d = zeros_q + ZW'(held_q);
						end
					end else if (fail_q) begin
						value_d = '1;
						state_d = bbr_pkg::ST_DONE;
					end else if (pos_q >= count_q) begin
						fail_d  = 1'b1;
						value_d = '1;
						state_d = bbr_pkg::ST_DONE;
					end else begin
						rd_en   = 1'b1;
						state_d = bbr_pkg::ST_FETCH;
					end
				end
			end

			bbr_pkg::ST_FETCH: begin
				if (rd_code[bbr_pkg::CODE_W-1]) begin
					// Character outside the alphabet: refill fails.
					fail_d  = 1'b1;
					value_d = (op_q == bbr_pkg::OP_READ_BITS) ? acc_ext[31:0] : '1;
					state_d = bbr_pkg::ST_DONE;
				end else begin
					buf_d   = rd_code[5:0];
					held_d  = 3'd6;
					pos_d   = pos_q + CW'(1);
					state_d = bbr_pkg::ST_RUN;
				end
			end

			bbr_pkg::ST_DONE: begin
				if (rsp_ready) begin
					state_d = bbr_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = bbr_pkg::ST_IDLE;
			end
		endcase
	end

	// Six bits for each unread character plus what the buffer still holds.
	assign unread      = count_q - pos_q;
	assign bits_left_w = (BW'(unread) << 2) + (BW'(unread) << 1) + BW'(held_q);

	assign req_ready          = (state_q == bbr_pkg::ST_IDLE);
	assign rsp_valid          = (state_q == bbr_pkg::ST_DONE);
	assign rsp_word.value     = value_q;
	assign rsp_word.failed    = fail_q;
	assign rsp_word.bits_left = 9'(bits_left_w);

endmodule

// ----- design/bbr_char_store.sv -----
// ---------------------------------------------------------------------------
// bbr_char_store: character code memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module bbr_char_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [bbr_pkg::CODE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [bbr_pkg::CODE_W-1:0] rd_data
);

	logic [bbr_pkg::CODE_W-1:0] mem [DEPTH];
	logic [bbr_pkg::CODE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/bbr_bit_unit.sv -----
// ---------------------------------------------------------------------------
// bbr_bit_unit: shared bit extraction unit
// Takes a group of bits from the six-bit buffer and finds the first one bit.
// ---------------------------------------------------------------------------
module bbr_bit_unit (
	input  bbr_pkg::unit_ctl_t ctl,
	input  logic [5:0]         bits,
	input  logic [2:0]         held,
	input  logic [2:0]         limit,
	output bbr_pkg::unit_res_t res
);

	logic [5:0] masked;
	logic [2:0] tz;
	logic       found;
	logic [2:0] k;

	always_comb begin
		masked = bits & ~(6'h3F << held);
		found  = |masked;
		tz     = 3'd0;
		for (int i = 5; i >= 0; i--) begin
			if (masked[i]) begin
				tz = 3'(i);
			end
		end
		if (ctl.single) begin
			k = 3'd1;
		end else if (ctl.unary) begin
			k = found ? 3'(tz + 3'd1) : held;
		end else begin
			k = (held < limit) ? held : limit;
		end
		res.k        = k;
		res.chunk    = bits & ~(6'h3F << k);
		res.buf_next = bits >> k;
		res.found    = found;
		res.tz       = tz;
	end

endmodule
